### rtl/sqln_pkg.sv
// Shared types, character constants and helper functions for the SQL text
// literal normalizer. No dependencies; every file but the two interfaces imports it.
`default_nettype none

package sqln_pkg;

  localparam int PENDING_DEPTH_DEF = 16;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;

  localparam logic [6:0] LIT_MAX = 7'd99;

  typedef enum logic [1:0] {
    KIND_TEXT    = 2'd0,
    KIND_LITERAL = 2'd1,
    KIND_END     = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_NUMBER = 2'd1,
    MODE_STRING = 2'd2
  } mode_t;

  // What an accepted byte does, decided from the byte and the scan state.
  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_LIT,
    ACT_PUSH,
    ACT_OPEN,
    ACT_TEXT
  } act_t;

  typedef enum logic [2:0] {
    SRC_PEND,
    SRC_DOLLAR,
    SRC_TENS,
    SRC_ONES,
    SRC_LIT,
    SRC_TEXT,
    SRC_END
  } src_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROLL,
    ST_FLUSH,
    ST_DOLLAR,
    ST_TENS,
    ST_ONES,
    ST_LIT,
    ST_TEXT,
    ST_END
  } state_t;

  typedef struct packed {
    logic accept;
    logic emit;
    src_t src;
    logic pop;
    logic roll;
    logic clear;
  } cmd_t;

  typedef struct packed {
    act_t act;
    logic pend_full;
    logic pend_empty;
    logic pend_last;
    logic tens_needed;
    logic eos;
    logic slot_free;
  } status_t;

  function automatic logic is_delim(input logic [7:0] c);
    return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) || (c == CH_PCT) ||
           (c == CH_EQ) || (c == CH_LT) || (c == CH_GT) || (c == CH_SPACE);
  endfunction

  // Multiply by 205/2048 gives the exact quotient by ten for values below 1029.
  function automatic logic [3:0] tens_of(input logic [6:0] v);
    logic [14:0] p;
    p = 15'(v) * 15'd205;
    return p[14:11];
  endfunction

  function automatic logic [3:0] ones_of(input logic [6:0] v);
    logic [6:0] r;
    r = v - 7'(tens_of(v)) * 7'd10;
    return r[3:0];
  endfunction

endpackage

`default_nettype wire

### rtl/sqln_in_if.sv
// Input channel of the normalizer: valid/ready handshake with one text byte
// and its end-of-statement flag. Depends on nothing.
`default_nettype none

interface sqln_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       end_of_statement;

  modport source (output valid, output ch, output end_of_statement, input ready);
  modport sink (input valid, input ch, input end_of_statement, output ready);
endinterface

`default_nettype wire

### rtl/sqln_out_if.sv
// Output channel of the normalizer: valid/ready handshake with one result
// word. Depends on nothing.
`default_nettype none

interface sqln_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] kind;
  logic [6:0] literal_number;
  logic       last;

  modport source (output valid, output out_byte, output kind, output literal_number,
                  output last, input ready);
  modport sink (input valid, input out_byte, input kind, input literal_number,
                input last, output ready);
endinterface

`default_nettype wire

### rtl/sqln_dp.sv
// Datapath of the normalizer: scan state, held-back space/semicolon queue,
// literal counter and the output register. Uses sqln_pkg.
`default_nettype none

module sqln_dp
  import sqln_pkg::*;
#(
  parameter int PENDING_DEPTH = PENDING_DEPTH_DEF
) (
  input  wire          clk,
  input  wire          rst,
  input  wire  [7:0]   ch,
  input  wire          end_of_statement,
  input  cmd_t         cmd,
  output status_t      status,
  input  wire          out_ready,
  output logic         out_valid,
  output logic [7:0]   out_byte,
  output logic [1:0]   out_kind,
  output logic [6:0]   out_number,
  output logic         out_last
);

  localparam int LENW = $clog2(PENDING_DEPTH + 1);
  localparam int IDXW = $clog2(PENDING_DEPTH);

  mode_t                    mode;
  logic [7:0]               prev_char;
  logic                     at_start;
  logic [6:0]               lit_count;
  logic [PENDING_DEPTH-1:0] pend_bits;
  logic [LENW-1:0]          pend_len;
  logic [7:0]               held_ch;
  logic                     held_eos;

  logic       is_digit;
  logic       is_ws;
  logic       is_semi;
  logic       delim;
  act_t       act;
  logic [6:0] count_next;
  logic       pend_full;

  logic [7:0] word_byte;
  logic [1:0] word_kind;
  logic [6:0] word_number;
  logic       word_last;

  always_comb begin
    is_digit   = (ch >= CH_ZERO) && (ch <= CH_NINE);
    is_ws      = (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));
    is_semi    = (ch == CH_SEMI);
    delim      = at_start || is_delim(prev_char);
    count_next = (lit_count < LIT_MAX) ? lit_count + 7'd1 : lit_count;
    pend_full  = (pend_len == LENW'(PENDING_DEPTH));

    if ((mode == MODE_NUMBER) && (is_digit || (ch == CH_DOT))) begin
      act = ACT_LIT;
    end else if (mode == MODE_STRING) begin
      act = ACT_LIT;
    end else if (is_ws) begin
      act = (!at_start && (prev_char != CH_SPACE)) ? ACT_PUSH : ACT_NONE;
    end else if (is_semi) begin
      act = ACT_PUSH;
    end else if ((is_digit || (ch == CH_QUOTE)) && delim) begin
      act = ACT_OPEN;
    end else begin
      act = ACT_TEXT;
    end

    status.act         = act;
    status.pend_full   = pend_full;
    status.pend_empty  = (pend_len == '0);
    status.pend_last   = (pend_len == LENW'(1));
    status.tens_needed = (lit_count >= 7'd10);
    status.eos         = held_eos;
    status.slot_free   = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      held_ch  <= ch;
      held_eos <= end_of_statement;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_NORMAL;
      prev_char <= CH_NUL;
      at_start  <= 1'b1;
      lit_count <= '0;
      pend_bits <= '0;
      pend_len  <= '0;
    end else if (cmd.clear) begin
      mode      <= MODE_NORMAL;
      prev_char <= CH_NUL;
      at_start  <= 1'b1;
      lit_count <= '0;
      pend_bits <= '0;
      pend_len  <= '0;
    end else if (cmd.accept) begin
      case (act)
        ACT_LIT: begin
          if ((mode == MODE_STRING) && (ch == CH_QUOTE)) begin
            mode <= MODE_NORMAL;
          end
        end
        ACT_NONE: begin
          mode <= MODE_NORMAL;
        end
        ACT_PUSH: begin
          mode      <= MODE_NORMAL;
          prev_char <= is_semi ? CH_SEMI : CH_SPACE;
          if (is_semi) begin
            at_start <= 1'b0;
          end
          // A full queue makes room first; the roll step inserts the byte.
          if (!pend_full) begin
            pend_bits[pend_len[IDXW-1:0]] <= is_semi;
            pend_len                      <= pend_len + LENW'(1);
          end
        end
        ACT_OPEN: begin
          mode      <= is_digit ? MODE_NUMBER : MODE_STRING;
          lit_count <= count_next;
          prev_char <= CH_ZERO + {4'b0000, ones_of(count_next)};
          at_start  <= 1'b0;
        end
        ACT_TEXT: begin
          mode      <= MODE_NORMAL;
          prev_char <= ch;
          at_start  <= 1'b0;
        end
        default: begin
          mode <= mode;
        end
      endcase
    end else if (cmd.roll) begin
      pend_bits <= {(held_ch == CH_SEMI), pend_bits[PENDING_DEPTH-1:1]};
    end else if (cmd.pop) begin
      pend_bits <= pend_bits >> 1;
      pend_len  <= pend_len - LENW'(1);
    end
  end

  always_comb begin
    word_byte   = CH_NUL;
    word_kind   = KIND_TEXT;
    word_number = '0;
    word_last   = 1'b0;
    case (cmd.src)
      SRC_PEND:   word_byte = pend_bits[0] ? CH_SEMI : CH_SPACE;
      SRC_DOLLAR: word_byte = CH_DOLLAR;
      SRC_TENS:   word_byte = CH_ZERO + {4'b0000, tens_of(lit_count)};
      SRC_ONES:   word_byte = CH_ZERO + {4'b0000, ones_of(lit_count)};
      SRC_LIT: begin
        word_byte   = held_ch;
        word_kind   = KIND_LITERAL;
        word_number = lit_count;
      end
      SRC_TEXT:   word_byte = held_ch;
      SRC_END: begin
        word_kind = KIND_END;
        word_last = 1'b1;
      end
      default:    word_byte = CH_NUL;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_byte   <= word_byte;
      out_kind   <= word_kind;
      out_number <= word_number;
      out_last   <= word_last;
    end
  end

endmodule

`default_nettype wire

### rtl/sqln_ctrl.sv
// Controller of the normalizer: sequences the result words of one input byte
// (queue flush, tag digits, literal or text byte, end marker). Uses sqln_pkg.
`default_nettype none

module sqln_ctrl
  import sqln_pkg::*;
(
  input  wire     clk,
  input  wire     rst,
  input  wire     in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;
  logic   opening;
  logic   opening_next;
  state_t done_state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      opening <= 1'b0;
    end else begin
      state   <= state_next;
      opening <= opening_next;
    end
  end

  always_comb begin
    state_next   = state;
    opening_next = opening;
    in_ready     = 1'b0;
    cmd          = '{accept: 1'b0, emit: 1'b0, src: SRC_PEND, pop: 1'b0,
                     roll: 1'b0, clear: 1'b0};
    done_state   = status.eos ? ST_END : ST_IDLE;

    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          // The end flag is not registered yet, so route on the live input.
          case (status.act)
            ACT_LIT:  state_next = ST_LIT;
            ACT_NONE: state_next = ST_END;
            ACT_PUSH: state_next = status.pend_full ? ST_ROLL : ST_END;
            ACT_OPEN: begin
              opening_next = 1'b1;
              state_next   = status.pend_empty ? ST_DOLLAR : ST_FLUSH;
            end
            ACT_TEXT: begin
              opening_next = 1'b0;
              state_next   = status.pend_empty ? ST_TEXT : ST_FLUSH;
            end
            default:  state_next = ST_IDLE;
          endcase
        end
      end
      ST_ROLL: begin
        cmd.src = SRC_PEND;
        if (status.slot_free) begin
          cmd.emit   = 1'b1;
          cmd.roll   = 1'b1;
          state_next = done_state;
        end
      end
      ST_FLUSH: begin
        cmd.src = SRC_PEND;
        if (status.slot_free) begin
          cmd.emit = 1'b1;
          cmd.pop  = 1'b1;
          if (status.pend_last) begin
            state_next = opening ? ST_DOLLAR : ST_TEXT;
          end
        end
      end
      ST_DOLLAR: begin
        cmd.src = SRC_DOLLAR;
        if (status.slot_free) begin
          cmd.emit   = 1'b1;
          state_next = status.tens_needed ? ST_TENS : ST_ONES;
        end
      end
      ST_TENS: begin
        cmd.src = SRC_TENS;
        if (status.slot_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_ONES;
        end
      end
      ST_ONES: begin
        cmd.src = SRC_ONES;
        if (status.slot_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_LIT;
        end
      end
      ST_LIT: begin
        cmd.src = SRC_LIT;
        if (status.slot_free) begin
          cmd.emit   = 1'b1;
          state_next = done_state;
        end
      end
      ST_TEXT: begin
        cmd.src = SRC_TEXT;
        if (status.slot_free) begin
          cmd.emit   = 1'b1;
          state_next = done_state;
        end
      end
      ST_END: begin
        // Entered right after accept too; the end flag is registered by then.
        if (!status.eos) begin
          state_next = ST_IDLE;
        end else begin
          cmd.src = SRC_END;
          if (status.slot_free) begin
            cmd.emit   = 1'b1;
            cmd.clear  = 1'b1;
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/sql_text_literal_normalizer_top.sv
// A result word is registered at its emit step and shows on the output in the
// next cycle. The input is ready only in the idle state, once every result word
// of the previous byte has been emitted. The emit sequencer sends one word per
// cycle while the output is not stalled, through a single output register.
// Reset (rst, synchronous) empties the queue and returns the scan state to the
// start of a statement. Uses sqln_pkg, sqln_in_if, sqln_out_if, sqln_ctrl, sqln_dp.
`default_nettype none

module sql_text_literal_normalizer_top
  import sqln_pkg::*;
#(
  parameter int PENDING_DEPTH = PENDING_DEPTH_DEF
) (
  input wire          clk,
  input wire          rst,
  sqln_in_if.sink     in_chan,
  sqln_out_if.source  out_chan
);

  cmd_t    cmd;
  status_t status;

  sqln_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .status   (status),
    .cmd      (cmd)
  );

  sqln_dp #(
    .PENDING_DEPTH (PENDING_DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .ch               (in_chan.ch),
    .end_of_statement (in_chan.end_of_statement),
    .cmd              (cmd),
    .status           (status),
    .out_ready        (out_chan.ready),
    .out_valid        (out_chan.valid),
    .out_byte         (out_chan.out_byte),
    .out_kind         (out_chan.kind),
    .out_number       (out_chan.literal_number),
    .out_last         (out_chan.last)
  );

endmodule

`default_nettype wire

### rtl/sqln_checker.sv
// Port-level checks on the normalizer's output words, bound to the top level.
// Uses sqln_pkg for the kind codes and character constants.
`default_nettype none

module sqln_checker
  import sqln_pkg::*;
(
  input wire       clk,
  input wire       rst,
  input wire       out_valid,
  input wire       out_ready,
  input wire [7:0] out_byte,
  input wire [1:0] out_kind,
  input wire [6:0] out_number,
  input wire       out_last
);

  // A stalled word stays put.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_kind) &&
                                $stable(out_number) && $stable(out_last))
    else $error("output word changed while stalled");

  // Only the end marker carries last, and it has no payload.
  a_end_marker: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_last == (out_kind == KIND_END)) &&
                  (out_kind != KIND_END || (out_byte == CH_NUL && out_number == 7'd0)))
    else $error("malformed end marker");

  // Literal bytes belong to a numbered literal; text words carry no number.
  a_lit_number: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_kind == KIND_LITERAL) ? (out_number != 7'd0 && out_number <= LIT_MAX)
                                             : (out_number == 7'd0))
    else $error("literal number out of range");

  // Reset leaves no word on the output.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

endmodule

bind sql_text_literal_normalizer_top sqln_checker u_sqln_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .out_byte   (out_chan.out_byte),
  .out_kind   (out_chan.kind),
  .out_number (out_chan.literal_number),
  .out_last   (out_chan.last)
);

`default_nettype wire

### bench/testbench.sv
// Self-checking bench for sql_text_literal_normalizer_top: streams statements through
// the input channel and compares each output word against a behavioral normalizer.
// Depends on sqln_pkg, sqln_in_if, sqln_out_if and the normalizer RTL.
module testbench;
  import sqln_pkg::*;

  localparam int HELD_DEPTH = PENDING_DEPTH_DEF;
  localparam int IDLE_LIMIT = 5000;
  localparam int STIM_ITEMS = 400;

  typedef struct packed {
    logic [7:0] data;
    kind_t      kind;
    logic [6:0] num;
    logic       last;
  } word_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       eos;
  } in_word_t;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_MOSTLY,
    RX_SPARSE,
    RX_PATTERN
  } rx_style_t;

  logic clk;
  logic rst;

  sqln_in_if  in_chan();
  sqln_out_if out_chan();

  sql_text_literal_normalizer_top #(.PENDING_DEPTH(HELD_DEPTH)) dut (
    .clk(clk),
    .rst(rst),
    .in_chan(in_chan),
    .out_chan(out_chan)
  );

  // Normalizer state as the bench tracks it.
  mode_t      scan;
  logic [7:0] prev_ch;
  logic       fresh;
  logic [6:0] lit_cnt;
  logic       held_semi [HELD_DEPTH];
  int         held_len;

  word_t      expected_words[$];
  in_word_t   send_queue[$];
  logic [7:0] stmt[$];
  logic [7:0] delim_set [8] = '{CH_PLUS, CH_MINUS, CH_STAR, CH_PCT, CH_EQ, CH_LT, CH_GT,
                                CH_SPACE};

  logic      in_fire;
  int        mismatches;
  int        idle_cycles;
  int        burst_left;
  int        gap_left;
  int        stall_left;
  rx_style_t rx_style;
  logic [7:0] rx_pattern;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Behavioral normalizer
  // ---------------------------------------------------------------------------
  task expect_word(input logic [7:0] data, input kind_t kind, input logic [6:0] num,
                   input logic last);
    word_t w;
    w.data = data;
    w.kind = kind;
    w.num  = num;
    w.last = last;
    expected_words = {expected_words, w};
  endtask

  task clear_scan_state();
    scan     = MODE_NORMAL;
    prev_ch  = CH_NUL;
    fresh    = 1'b1;
    lit_cnt  = '0;
    held_len = 0;
    for (int i = 0; i < HELD_DEPTH; i++) held_semi[i] = 1'b0;
  endtask

  task release_held();
    for (int i = 0; i < held_len; i++)
      expect_word(held_semi[i] ? CH_SEMI : CH_SPACE, KIND_TEXT, '0, 1'b0);
    held_len = 0;
  endtask

  // When the hold buffer is full, the oldest held byte leaks out as text.
  task hold_byte(input logic semi);
    if (held_len >= HELD_DEPTH) begin
      expect_word(held_semi[0] ? CH_SEMI : CH_SPACE, KIND_TEXT, '0, 1'b0);
      for (int i = 1; i < HELD_DEPTH; i++) held_semi[i-1] = held_semi[i];
      held_len = HELD_DEPTH - 1;
    end
    held_semi[held_len] = semi;
    held_len++;
  endtask

  task open_literal();
    logic [7:0] ones;
    if (lit_cnt < LIT_MAX) lit_cnt++;
    release_held();
    expect_word(CH_DOLLAR, KIND_TEXT, '0, 1'b0);
    if (lit_cnt >= 7'd10) expect_word(CH_ZERO + 8'(lit_cnt / 7'd10), KIND_TEXT, '0, 1'b0);
    ones = CH_ZERO + 8'(lit_cnt % 7'd10);
    expect_word(ones, KIND_TEXT, '0, 1'b0);
    prev_ch = ones;
    fresh   = 1'b0;
  endtask

  function automatic logic opens_after(input logic [7:0] c);
    foreach (delim_set[i]) if (delim_set[i] == c) return 1'b1;
    return 1'b0;
  endfunction

  task normalize_byte(input logic [7:0] c, input logic eos);
    logic digit;
    logic taken;
    logic ws;
    logic may_open;
    digit = (c >= CH_ZERO) && (c <= CH_NINE);
    taken = 1'b0;
    if (scan == MODE_NUMBER) begin
      if (digit || c == CH_DOT) begin
        expect_word(c, KIND_LITERAL, lit_cnt, 1'b0);
        taken = 1'b1;
      end else begin
        scan = MODE_NORMAL;
      end
    end else if (scan == MODE_STRING) begin
      expect_word(c, KIND_LITERAL, lit_cnt, 1'b0);
      if (c == CH_QUOTE) scan = MODE_NORMAL;
      taken = 1'b1;
    end
    if (!taken) begin
      ws = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
      if (ws) begin
        if (!fresh && prev_ch != CH_SPACE) begin
          hold_byte(1'b0);
          prev_ch = CH_SPACE;
        end
      end else if (c == CH_SEMI) begin
        hold_byte(1'b1);
        prev_ch = CH_SEMI;
        fresh   = 1'b0;
      end else begin
        may_open = fresh || opens_after(prev_ch);
        if (may_open && (digit || c == CH_QUOTE)) begin
          open_literal();
          expect_word(c, KIND_LITERAL, lit_cnt, 1'b0);
          scan = digit ? MODE_NUMBER : MODE_STRING;
        end else begin
          release_held();
          expect_word(c, KIND_TEXT, '0, 1'b0);
          prev_ch = c;
          fresh   = 1'b0;
        end
      end
    end
    // Held bytes are dropped at the end of a statement.
    if (eos) begin
      expect_word(CH_NUL, KIND_END, '0, 1'b1);
      clear_scan_state();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Statement builders
  // ---------------------------------------------------------------------------
  task add_byte(input logic [7:0] b);
    stmt = {stmt, b};
  endtask

  task add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  task close_statement();
    in_word_t w;
    for (int i = 0; i < stmt.size(); i++) begin
      w.ch  = stmt[i];
      w.eos = (i == stmt.size() - 1);
      send_queue = {send_queue, w};
    end
    stmt.delete();
  endtask

  function automatic logic [7:0] any_ws();
    int pick;
    pick = $urandom_range(9, 14);
    return (pick == 14) ? CH_SPACE : 8'(pick);
  endfunction

  task add_token();
    int pick;
    int n;
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      n = $urandom_range(1, 6);
      repeat (n) add_byte(8'h61 + 8'($urandom_range(0, 25)));
    end else if (pick < 35) begin
      add_byte(delim_set[$urandom_range(0, 7)]);
    end else if (pick < 50) begin
      if ($urandom_range(0, 9) < 6) add_byte(delim_set[$urandom_range(0, 7)]);
      n = $urandom_range(1, 5);
      repeat (n) add_byte(($urandom_range(0, 6) == 0) ? CH_DOT :
                          CH_ZERO + 8'($urandom_range(0, 9)));
    end else if (pick < 62) begin
      if ($urandom_range(0, 9) < 6) add_byte(delim_set[$urandom_range(0, 7)]);
      add_byte(CH_QUOTE);
      n = $urandom_range(0, 6);
      repeat (n) add_byte(8'($urandom_range(0, 255)));
      // Some strings stay open and swallow what follows.
      if ($urandom_range(0, 6) != 0) add_byte(CH_QUOTE);
    end else if (pick < 78) begin
      n = $urandom_range(1, 3);
      repeat (n) add_byte(any_ws());
    end else if (pick < 86) begin
      n = $urandom_range(1, 22);
      repeat (n) add_byte(($urandom_range(0, 2) == 0) ? any_ws() : CH_SEMI);
    end else begin
      add_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Input driver: bursts with random gaps, fed from send_queue.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    in_fire = !rst && in_chan.valid && in_chan.ready;
    if (in_fire) normalize_byte(in_chan.ch, in_chan.end_of_statement);
  end

  always @(negedge clk) begin : feed_proc
    in_word_t nxt;
    logic drive;
    drive = 1'b0;
    if (rst) begin
      in_chan.valid <= 1'b0;
      in_chan.ch <= CH_NUL;
      in_chan.end_of_statement <= 1'b0;
    end else if (!in_chan.valid || in_fire) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 48);
        gap_left   = ($urandom_range(0, 4) < 2) ? 0 : $urandom_range(1, 10);
      end
      if (gap_left > 0) begin
        gap_left--;
      end else if (send_queue.size() != 0) begin
        nxt = send_queue.pop_front();
        drive = 1'b1;
        burst_left--;
        in_chan.ch <= nxt.ch;
        in_chan.end_of_statement <= nxt.eos;
      end
      in_chan.valid <= drive;
    end
  end

  // ---------------------------------------------------------------------------
  // Output side: ready follows a random style that changes when its stall_left run is spent.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : ready_proc
    logic r;
    r = 1'b1;
    if (!rst) begin
      if (stall_left == 0) begin
        rx_style   = rx_style_t'($urandom_range(0, 3));
        stall_left = $urandom_range(20, 300);
        rx_pattern = 8'($urandom_range(0, 255)) | 8'h01;
      end
      stall_left--;
      case (rx_style)
        RX_OPEN:    r = 1'b1;
        RX_MOSTLY:  r = ($urandom_range(0, 3) != 0);
        RX_SPARSE:  r = ($urandom_range(0, 3) == 0);
        RX_PATTERN: begin
          r = rx_pattern[0];
          rx_pattern = {rx_pattern[0], rx_pattern[7:1]};
        end
      endcase
    end
    out_chan.ready <= r;
  end

  always @(posedge clk) begin : check_proc
    word_t seen;
    word_t want;
    idle_cycles <= (rst || (in_chan.valid && in_chan.ready) ||
                    (out_chan.valid && out_chan.ready)) ? 0 : idle_cycles + 1;
    if (!rst && out_chan.valid && out_chan.ready) begin
      seen.data = out_chan.out_byte;
      seen.kind = kind_t'(out_chan.kind);
      seen.num  = out_chan.literal_number;
      seen.last = out_chan.last;
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word: expected none, got byte %02h kind %0d num %0d last %0b",
                 $time, seen.data, seen.kind, seen.num, seen.last);
        mismatches++;
      end else begin
        want = expected_words.pop_front();
        if (seen.data !== want.data || seen.kind !== want.kind ||
            seen.num !== want.num || seen.last !== want.last) begin
          $display("%0t: word mismatch: expected byte %02h kind %0d num %0d last %0b,",
                   $time, want.data, want.kind, want.num, want.last);
          $display("%0t:   actual byte %02h kind %0d num %0d last %0b",
                   $time, seen.data, seen.kind, seen.num, seen.last);
          mismatches++;
        end
      end
    end
  end

  initial begin
    wait (rst === 1'b0);
    while (idle_cycles < IDLE_LIMIT) @(negedge clk);
    $display("Simulation FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    rst = 1'b1;
    in_fire = 1'b0;
    mismatches = 0;
    burst_left = 0;
    gap_left = 0;
    stall_left = 0;
    rx_style = RX_OPEN;
    rx_pattern = 8'hFF;
    clear_scan_state();

    // Leading whitespace, a number at the very start, a held semicolon.
    add_text(" \t42.5;");
    close_statement();
    // A string after '=' that never closes.
    add_text("x='a");
    close_statement();
    // A quote right after a number is plain text.
    add_text("1'z");
    close_statement();
    // Byte extremes, collapsed whitespace, a closed string after '<'.
    add_byte(8'hFF);
    add_byte(CH_NUL);
    add_byte(CH_CR);
    add_byte(8'h0B);
    add_text("<'q'");
    close_statement();
    add_text("5 ;z");
    close_statement();

    // Literal counter runs past 99 and saturates.
    for (int k = 0; k < 101; k++) begin
      add_byte(CH_ZERO + 8'($urandom_range(0, 9)));
      add_byte(delim_set[$urandom_range(0, 7)]);
    end
    add_text("x");
    close_statement();
    // Long runs of semicolons and spaces overflow the hold buffer.
    add_text("a");
    repeat (20) add_byte(CH_SEMI);
    add_text("b ");
    repeat (24) add_byte(($urandom_range(0, 1) == 0) ? any_ws() : CH_SEMI);
    close_statement();

    while (send_queue.size() < STIM_ITEMS) begin
      repeat ($urandom_range(1, 12)) add_token();
      close_statement();
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (send_queue.size() != 0 || in_chan.valid) @(negedge clk);
    while (expected_words.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (mismatches == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
